// ===== hw/rtl/bmio_pkg.sv =====
// Shared types and codes for the banked memory and I/O decoder.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none

package bmio_pkg;

  typedef enum logic [2:0] {
    TGT_MEM  = 3'd0,
    TGT_IDE  = 3'd1,
    TGT_PIDE = 3'd2,
    TGT_NET  = 3'd3,
    TGT_RTC  = 3'd4,
    TGT_NONE = 3'd5
  } target_e;

  // Memory mode codes; code 3 behaves as flat.
  localparam logic [1:0] MODE_FLAT  = 2'd0;
  localparam logic [1:0] MODE_PAGED = 2'd1;
  localparam logic [1:0] MODE_MMU   = 2'd2;

  // Disk mode codes; code 3 behaves as no disk.
  localparam logic [1:0] DISK_NONE = 2'd0;
  localparam logic [1:0] DISK_IDE  = 2'd1;
  localparam logic [1:0] DISK_PIDE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MEM_MODE  = 2'd0;
  localparam logic [1:0] CFG_DISK_MODE = 2'd1;
  localparam logic [1:0] CFG_NET_EN    = 2'd2;
  localparam logic [1:0] CFG_RTC_EN    = 2'd3;

  localparam logic [7:0] IO_PAGE      = 8'hFE;
  localparam logic [7:0] PORT_MMU     = 8'hFF;
  localparam logic [15:0] MMU_HI_BASE = 16'hE000;

  typedef struct packed {
    logic        action;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        debug_access;
  } in_t;

  typedef struct packed {
    target_e     target;
    logic [19:0] phys_address;
    logic        mem_write;
    logic [2:0]  device_register;
    logic        device_write;
    logic [7:0]  out_data;
  } out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/banked_memory_and_io_decoder_core.sv =====
// Throughput: one access per cycle while the receiver takes results; decode is
// a single pass from the accepted beat and the bank state into a two-entry
// output buffer.
// Reset: configuration, bank registers, bank enable and MMU register clear to
// zero (flat mode, no devices); the output buffer empties.
// Depends on bmio_pkg, bmio_io_decode, bmio_translate, bmio_out_skid.
`default_nettype none

module banked_memory_and_io_decoder_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  bmio_pkg::in_t    in_item_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output bmio_pkg::out_t   out_item_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);
  import bmio_pkg::*;

  logic [1:0]      mem_mode_q, disk_mode_q;
  logic            net_en_q, rtc_en_q;
  logic [3:0][5:0] bank_q;
  logic            bank_on_q;
  logic [7:0]      mmu_q;

  logic [3:0][5:0] bank_d;
  logic            bank_on_d;
  logic [7:0]      mmu_d;

  logic        accept;
  logic        is_io;
  logic [7:0]  port;
  target_e     dev_target;
  logic [2:0]  dev_reg;
  logic [19:0] phys;
  logic        writable;
  out_t        res;

  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign is_io       = in_item_i.address[15:8] == IO_PAGE;
  assign port        = in_item_i.address[7:0];

  bmio_io_decode u_io_decode (
    .port_i      (port),
    .disk_mode_i (disk_mode_q),
    .net_en_i    (net_en_q),
    .rtc_en_i    (rtc_en_q),
    .target_o    (dev_target),
    .reg_o       (dev_reg)
  );

  bmio_translate u_translate (
    .addr_i       (in_item_i.address),
    .mem_mode_i   (mem_mode_q),
    .bank_on_i    (bank_on_q),
    .bank_table_i (bank_q),
    .mmu_i        (mmu_q),
    .phys_o       (phys),
    .writable_o   (writable)
  );

  always_comb begin
    res           = '0;
    res.target    = TGT_NONE;
    res.out_data  = in_item_i.action ? in_item_i.write_data : 8'd0;
    bank_d        = bank_q;
    bank_on_d     = bank_on_q;
    mmu_d         = mmu_q;

    if (is_io) begin
      if (!in_item_i.action) begin
        // Debug reads never reach a device.
        if (!in_item_i.debug_access) begin
          res.target          = dev_target;
          res.device_register = dev_reg;
        end
      end else if (port == PORT_MMU && mem_mode_q == MODE_MMU) begin
        mmu_d = in_item_i.write_data;
      end else begin
        res.target          = dev_target;
        res.device_register = dev_reg;
        if (dev_target != TGT_NONE) begin
          res.device_write = 1'b1;
        end else if (mem_mode_q == MODE_PAGED && (port inside {[8'h78:8'h7B]})) begin
          bank_d[port[1:0]] = in_item_i.write_data[5:0];
        end else if (mem_mode_q == MODE_PAGED && (port inside {[8'h7C:8'h7F]})) begin
          bank_on_d = in_item_i.write_data[0];
        end
      end
    end else begin
      res.target       = TGT_MEM;
      res.phys_address = phys;
      res.mem_write    = in_item_i.action && writable;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_mode_q  <= MODE_FLAT;
      disk_mode_q <= DISK_NONE;
      net_en_q    <= 1'b0;
      rtc_en_q    <= 1'b0;
      bank_q      <= '0;
      bank_on_q   <= 1'b0;
      mmu_q       <= 8'd0;
    end else begin
      if (accept) begin
        bank_q    <= bank_d;
        bank_on_q <= bank_on_d;
        mmu_q     <= mmu_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_MEM_MODE: begin
            mem_mode_q <= cfg_data_i[1:0];
            bank_on_q  <= (cfg_data_i[1:0] == MODE_PAGED) ||
                          (cfg_data_i[1:0] == MODE_MMU);
          end
          CFG_DISK_MODE: disk_mode_q <= cfg_data_i[1:0];
          CFG_NET_EN:    net_en_q    <= cfg_data_i[0];
          CFG_RTC_EN:    rtc_en_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  bmio_out_skid u_out_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (res),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/bmio_io_decode.sv =====
// Port decoder for the I/O page: maps a port number to a device window.
// Depends on bmio_pkg.
`default_nettype none

module bmio_io_decode (
  input  wire logic [7:0]       port_i,
  input  wire logic [1:0]       disk_mode_i,
  input  wire logic             net_en_i,
  input  wire logic             rtc_en_i,
  output bmio_pkg::target_e     target_o,
  output logic [2:0]            reg_o
);
  import bmio_pkg::*;

  always_comb begin
    target_o = TGT_NONE;
    reg_o    = 3'd0;
    if (disk_mode_i == DISK_IDE &&
        (port_i inside {[8'h10:8'h17], [8'h90:8'h97]})) begin
      target_o = TGT_IDE;
      reg_o    = port_i[2:0];
    end else if (disk_mode_i == DISK_PIDE && (port_i inside {[8'h20:8'h23]})) begin
      target_o = TGT_PIDE;
      reg_o    = {1'b0, port_i[1:0]};
    end else if (net_en_i && (port_i inside {[8'h28:8'h2C]})) begin
      target_o = TGT_NET;
      reg_o    = {1'b0, port_i[1:0]};
    end else if (rtc_en_i && port_i == 8'h0C) begin
      target_o = TGT_RTC;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bmio_translate.sv =====
// Logical to physical address translation: flat, 16K banking, high MMU.
// Depends on bmio_pkg.
`default_nettype none

module bmio_translate (
  input  wire logic [15:0]      addr_i,
  input  wire logic [1:0]       mem_mode_i,
  input  wire logic             bank_on_i,
  input  wire logic [3:0][5:0]  bank_table_i,
  input  wire logic [7:0]       mmu_i,
  output logic [19:0]           phys_o,
  output logic                  writable_o
);
  import bmio_pkg::*;

  logic [7:0] mmu_r;
  logic [3:0] page;
  logic [5:0] bank;

  always_comb begin
    // Below the top 8K the page comes from the odd register bits.
    mmu_r = (addr_i < MMU_HI_BASE) ? {1'b0, mmu_i[7:1]} : mmu_i;
    page  = {mmu_r[0], mmu_r[2], mmu_r[4], mmu_r[6]};
    bank  = bank_table_i[addr_i[15:14]];

    if (mem_mode_i == MODE_MMU) begin
      phys_o     = {page, addr_i};
      writable_o = page[3];
    end else if (bank_on_i) begin
      phys_o     = {bank, addr_i[13:0]};
      writable_o = bank[5];
    end else begin
      phys_o     = {4'd0, addr_i};
      writable_o = addr_i[15] && (mem_mode_i != MODE_PAGED);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bmio_out_skid.sv =====
// Two-entry result buffer: output register plus skid register.
// Depends on bmio_pkg for the result beat type.
`default_nettype none

module bmio_out_skid (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  bmio_pkg::out_t     push_data_i,
  output logic               space_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output bmio_pkg::out_t     out_data_o
);
  import bmio_pkg::*;

  logic out_valid_q, skid_valid_q;
  out_t out_q, skid_q;

  assign space_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && out_ready_i) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else if (!push_i) begin
        out_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // Payload: advance the skid beat first, else take the new beat.
  always_ff @(posedge clk_i) begin
    if (out_valid_q && out_ready_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= push_data_i;
      end
    end else if (push_i) begin
      if (!out_valid_q) begin
        out_q <= push_data_i;
      end else begin
        skid_q <= push_data_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sim/bmio_checker.sv =====
// Checker for the banked memory and I/O decoder: tracks the configuration and bank
// registers, predicts each result beat and compares it with what the core returns.
// Depends on bmio_pkg for the beat types, target codes and register indexes.
`timescale 1ns / 1ps

module bmio_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  bmio_pkg::in_t     in_item_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  bmio_pkg::out_t    out_item_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       results_o
);
  import bmio_pkg::*;

  localparam logic [7:0] PORT_RTC     = 8'h0C;
  localparam logic [7:0] PORT_IDE_LO  = 8'h10;
  localparam logic [7:0] PORT_IDE_HI  = 8'h90;
  localparam logic [7:0] PORT_PIDE    = 8'h20;
  localparam logic [7:0] PORT_NET     = 8'h28;
  localparam logic [7:0] PORT_NET_END = 8'h2C;
  localparam logic [7:0] PORT_BANK    = 8'h78;
  localparam logic [7:0] PORT_BANK_ON = 8'h7C;

  // Shadow of the core's configuration and banking state
  logic [1:0] mem_mode;
  logic [1:0] disk_mode;
  logic       net_en;
  logic       rtc_en;
  logic [5:0] banks [4];
  logic       bank_on;
  logic [7:0] mmu_reg;

  out_t       decoded_q [$];
  out_t       want;

  function automatic target_e port_target(input logic [7:0] port, output logic [2:0] offs);
    offs = 3'd0;
    if (disk_mode == DISK_IDE &&
        ((port >= PORT_IDE_LO && port <= PORT_IDE_LO + 8'd7) ||
         (port >= PORT_IDE_HI && port <= PORT_IDE_HI + 8'd7))) begin
      offs = port[2:0];
      return TGT_IDE;
    end
    if (disk_mode == DISK_PIDE && port >= PORT_PIDE && port <= PORT_PIDE + 8'd3) begin
      offs = {1'b0, port[1:0]};
      return TGT_PIDE;
    end
    // the last port of the network window wraps to offset zero
    if (net_en && port >= PORT_NET && port <= PORT_NET_END) begin
      offs = {1'b0, port[1:0]};
      return TGT_NET;
    end
    if (rtc_en && port == PORT_RTC)
      return TGT_RTC;
    return TGT_NONE;
  endfunction

  // Decode one access and apply any banking register load it carries.
  function automatic out_t decode_access(input in_t acc);
    out_t       res;
    logic [7:0] port;
    logic [7:0] r;
    logic [3:0] page;
    logic [5:0] b;
    logic [2:0] offs;
    logic       keep;
    res = '0;
    res.target = TGT_NONE;
    port = acc.address[7:0];
    offs = 3'd0;
    if (acc.address[15:8] == IO_PAGE) begin
      if (!acc.action) begin
        // a debugger read must not reach a device
        if (!acc.debug_access)
          res.target = port_target(port, offs);
      end else if (port == PORT_MMU && mem_mode == MODE_MMU) begin
        mmu_reg = acc.write_data;
      end else begin
        res.target = port_target(port, offs);
        if (res.target != TGT_NONE)
          res.device_write = 1'b1;
        else if (mem_mode == MODE_PAGED && port[7:2] == PORT_BANK[7:2])
          banks[port[1:0]] = acc.write_data[5:0];
        else if (mem_mode == MODE_PAGED && port[7:2] == PORT_BANK_ON[7:2])
          bank_on = acc.write_data[0];
      end
      res.device_register = offs;
    end else begin
      res.target = TGT_MEM;
      if (mem_mode == MODE_MMU) begin
        // below the top 8K the register is read one bit to the right
        r = (acc.address < MMU_HI_BASE) ? (mmu_reg >> 1) : mmu_reg;
        page = {r[0], r[2], r[4], r[6]};
        keep = page[3];
        res.phys_address = {page, acc.address};
      end else if (bank_on) begin
        b = banks[acc.address[15:14]];
        keep = b[5];
        res.phys_address = {b, acc.address[13:0]};
      end else begin
        keep = acc.address[15] && mem_mode != MODE_PAGED;
        res.phys_address = {4'h0, acc.address};
      end
      res.mem_write = acc.action && keep;
    end
    res.out_data = acc.action ? acc.write_data : 8'h00;
    return res;
  endfunction

  task automatic report(input string field, input int unsigned exp_v, input int unsigned act_v);
    $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, exp_v, act_v);
    fail_count_o++;
  endtask

  task automatic compare_beat(input out_t exp_b, input out_t act_b);
    if (act_b.target !== exp_b.target)
      report("target", exp_b.target, act_b.target);
    if (act_b.phys_address !== exp_b.phys_address)
      report("phys_address", exp_b.phys_address, act_b.phys_address);
    if (act_b.mem_write !== exp_b.mem_write)
      report("mem_write", exp_b.mem_write, act_b.mem_write);
    if (act_b.device_register !== exp_b.device_register)
      report("device_register", exp_b.device_register, act_b.device_register);
    if (act_b.device_write !== exp_b.device_write)
      report("device_write", exp_b.device_write, act_b.device_write);
    if (act_b.out_data !== exp_b.out_data)
      report("out_data", exp_b.out_data, act_b.out_data);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_mode = MODE_FLAT;
      disk_mode = DISK_NONE;
      net_en = 1'b0;
      rtc_en = 1'b0;
      for (int i = 0; i < 4; i++) banks[i] = 6'd0;
      bank_on = 1'b0;
      mmu_reg = 8'h00;
      decoded_q.delete();
      fail_count_o = 0;
      results_o = 0;
    end else begin
      // retire first: a result never belongs to the beat taken at this edge
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (decoded_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none actual target 0x%0h addr 0x%0h",
                   $time, out_item_i.target, out_item_i.phys_address);
          fail_count_o++;
        end else begin
          want = decoded_q.pop_front();
          compare_beat(want, out_item_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MEM_MODE: begin
            mem_mode = cfg_data_i[1:0];
            bank_on = (mem_mode == MODE_PAGED || mem_mode == MODE_MMU);
          end
          CFG_DISK_MODE: disk_mode = cfg_data_i[1:0];
          CFG_NET_EN:    net_en = cfg_data_i[0];
          CFG_RTC_EN:    rtc_en = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        decoded_q.push_back(decode_access(in_item_i));
    end
    pending_o = decoded_q.size();
  end

endmodule

// ===== sim/banked_memory_and_io_decoder_core_tb.sv =====
// Top of the decoder testbench: clock, reset, access and register-write stimulus,
// receiver back-pressure, watchdog and verdict. Depends on bmio_pkg, bmio_checker
// and the banked_memory_and_io_decoder_core RTL.
`timescale 1ns / 1ps

module banked_memory_and_io_decoder_core_tb;
  import bmio_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 60;
  localparam int unsigned RAND_PHASES    = 8;
  localparam int unsigned PHASE_ITEMS    = 50;

  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic [7:0] PORT_RTC     = 8'h0C;
  localparam logic [7:0] PORT_IDE_LO  = 8'h10;
  localparam logic [7:0] PORT_IDE_HI  = 8'h90;
  localparam logic [7:0] PORT_PIDE    = 8'h20;
  localparam logic [7:0] PORT_NET     = 8'h28;
  localparam logic [7:0] PORT_BANK    = 8'h78;
  localparam logic [7:0] PORT_BANK_ON = 8'h7C;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [7:0]  cfg_data = 8'h00;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results;
  int unsigned n_access = 0;
  int unsigned n_cfg = 0;
  int unsigned quiet = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  banked_memory_and_io_decoder_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  bmio_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results)
  );

  // Abort when no beat moves on any channel for too long
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog, no beat moved for %0d cycles", $time, quiet);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  always begin
    @(negedge clk_i);
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk_i);
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 12);
    end
  end

  task automatic send(input in_t acc);
    if (!calm && $urandom_range(0, 99) < 12) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_item <= acc;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    n_access++;
  endtask

  task automatic access(input logic wr, input logic [15:0] addr, input logic [7:0] data,
                        input logic dbg);
    in_t acc;
    acc.action = wr;
    acc.address = addr;
    acc.write_data = data;
    acc.debug_access = dbg;
    send(acc);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  task automatic set_config(input logic [1:0] mode, input logic [1:0] disk, input logic net,
                            input logic rtc);
    write_reg(CFG_MEM_MODE, {6'd0, mode});
    write_reg(CFG_DISK_MODE, {6'd0, disk});
    write_reg(CFG_NET_EN, {7'd0, net});
    write_reg(CFG_RTC_EN, {7'd0, rtc});
  endtask

  // Mostly memory traffic, with I/O page beats aimed at windows and banking ports
  task automatic rand_access();
    in_t        acc;
    logic [7:0] port;
    acc.action = 1'($urandom_range(0, 1));
    acc.address = 16'($urandom);
    acc.write_data = 8'($urandom);
    acc.debug_access = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 9) < 4) begin
      port = 8'($urandom);
      case ($urandom_range(0, 9))
        0: port = PORT_IDE_LO + 8'($urandom_range(0, 7));
        1: port = PORT_IDE_HI + 8'($urandom_range(0, 7));
        2: port = PORT_PIDE + 8'($urandom_range(0, 3));
        3: port = PORT_NET + 8'($urandom_range(0, 4));
        4: port = PORT_RTC;
        5, 6: begin
          port = PORT_BANK + 8'($urandom_range(0, 7));
          acc.action = ($urandom_range(0, 3) != 0);
        end
        7: begin
          port = PORT_MMU;
          acc.action = ($urandom_range(0, 3) != 0);
        end
        default: ;
      endcase
      acc.address = {IO_PAGE, port};
    end
    send(acc);
  endtask

  initial begin
    logic [1:0] mode;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // flat mode, no devices
    access(1'b1, 16'h0000, 8'h5A, 1'b0);
    access(1'b1, 16'h8000, 8'hFF, 1'b0);
    access(1'b0, 16'hFFFF, 8'h00, 1'b1);
    access(1'b0, {IO_PAGE, PORT_IDE_LO}, 8'h00, 1'b0);
    settle();

    set_config(MODE_FLAT, DISK_IDE, 1'b1, 1'b1);
    access(1'b0, {IO_PAGE, PORT_IDE_LO + 8'd7}, 8'h00, 1'b0);
    access(1'b1, {IO_PAGE, PORT_IDE_HI}, 8'hA5, 1'b0);
    access(1'b0, {IO_PAGE, PORT_NET}, 8'h00, 1'b1);
    access(1'b1, {IO_PAGE, PORT_NET + 8'd4}, 8'h01, 1'b1);
    access(1'b0, {IO_PAGE, PORT_RTC}, 8'h00, 1'b0);
    settle();

    write_reg(CFG_DISK_MODE, {6'd0, DISK_PIDE});
    access(1'b0, {IO_PAGE, PORT_PIDE + 8'd3}, 8'h00, 1'b0);
    access(1'b1, {IO_PAGE, PORT_PIDE}, 8'h3C, 1'b0);
    settle();

    // paged banking: load banks, translate, then switch banking off
    write_reg(CFG_MEM_MODE, {6'd0, MODE_PAGED});
    access(1'b1, {IO_PAGE, PORT_BANK}, 8'hFF, 1'b0);
    access(1'b1, {IO_PAGE, PORT_BANK + 8'd2}, 8'h20, 1'b0);
    access(1'b0, 16'h0000, 8'h00, 1'b0);
    access(1'b1, 16'h8123, 8'h11, 1'b0);
    access(1'b1, 16'h4000, 8'h22, 1'b0);
    access(1'b1, {IO_PAGE, PORT_BANK_ON}, 8'hFE, 1'b0);
    access(1'b1, 16'hC000, 8'h33, 1'b0);
    settle();

    write_reg(CFG_MEM_MODE, {6'd0, MODE_MMU});
    access(1'b1, {IO_PAGE, PORT_MMU}, 8'hFF, 1'b0);
    access(1'b1, 16'h0000, 8'h44, 1'b0);
    access(1'b1, 16'hFFFF, 8'h55, 1'b0);
    settle();

    // the spare mode code decodes as flat and ignores the MMU port
    write_reg(CFG_MEM_MODE, {6'd0, MODE_SPARE});
    access(1'b1, {IO_PAGE, PORT_MMU}, 8'h12, 1'b0);
    access(1'b1, 16'h9000, 8'h66, 1'b0);
    settle();

    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 2)
        mode = MODE_FLAT;
      else if (ph == 3)
        mode = MODE_SPARE;
      else
        mode = ph[0] ? MODE_MMU : MODE_PAGED;
      set_config(mode, 2'(ph % 4), (ph % 3) != 0, ph[1]);
      calm = (ph == 4);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        // keep offering beats while the receiver holds off
        if (ph == 1 && i == 10) begin
          calm = 1'b1;
          hold_req = 1'b1;
        end
        if (ph == 1 && i == 40)
          calm = 1'b0;
        if (ph == 5 && i == 25)
          settle();
        rand_access();
      end
      settle();
    end
    calm = 1'b0;
    repeat (4) @(negedge clk_i);

    $display("Run covered %0d accesses and %0d register writes; %0d results checked",
             n_access, n_cfg, results);
    $display("over flat, paged, MMU and spare memory modes and every disk mode.");
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bmio_pkg.sv
hw/rtl/bmio_io_decode.sv
hw/rtl/bmio_translate.sv
hw/rtl/bmio_out_skid.sv
hw/rtl/banked_memory_and_io_decoder_core.sv
sim/bmio_checker.sv
sim/banked_memory_and_io_decoder_core_tb.sv
